// File: sv/lmdf_pkg.sv
// Shared types, field widths, codes and font table for the LED matrix digit frame store.
package lmdf_pkg;

   // Field widths
   localparam int OP_W        = 2;
   localparam int NUMBER_W    = 32;
   localparam int START_X_W   = 4;
   localparam int START_Y_W   = 3;
   localparam int LED_INDEX_W = 7;
   localparam int COLOR_W     = 24;
   localparam int BRIGHT_W    = 8;
   localparam int CSR_ADDR_W  = 1;

   localparam int START_X_MAX = 15;
   localparam int START_Y_MAX = 7;

   // Default geometry
   localparam int DEF_ROWS       = 8;
   localparam int DEF_COLS       = 15;
   localparam int DEF_MAX_DIGITS = 4;

   // Font geometry
   localparam int FONT_ROWS   = 5;
   localparam int FONT_COLS   = 3;
   localparam int DIGIT_PITCH = 4;

   // Divider: divisor is 10 or COLS (at most 127)
   localparam int DIVISOR_W = 7;

   // Op codes
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
   localparam logic [OP_W-1:0] OP_DRAW  = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_BRIGHTNESS  = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_DIGIT_COLOR = 1'd1;

   localparam logic [BRIGHT_W-1:0] BRIGHTNESS_RESET = 8'd30;
   localparam logic [COLOR_W-1:0]  DIGIT_COLOR_RESET = 24'h3F3FFF;

   localparam logic [DIVISOR_W-1:0] DECIMAL_BASE = 7'd10;

   typedef struct packed {
      logic                   start;
      logic [NUMBER_W-1:0]    dividend;
      logic [DIVISOR_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic                   done;
      logic [NUMBER_W-1:0]    quotient;
      logic [DIVISOR_W-1:0]   remainder;
   } div_rsp_type;

   // One 3-bit font row, MSB is the leftmost column
   function automatic logic [FONT_COLS-1:0] font_row(input logic [3:0] digit,
                                                     input logic [2:0] row);
      logic [FONT_ROWS*FONT_COLS-1:0] glyph;
      int                             top;
      case (digit)
         4'd0:    glyph = 15'b111_101_101_101_111;
         4'd1:    glyph = 15'b010_010_010_010_010;
         4'd2:    glyph = 15'b111_001_111_100_111;
         4'd3:    glyph = 15'b111_001_111_001_111;
         4'd4:    glyph = 15'b101_101_111_001_001;
         4'd5:    glyph = 15'b111_100_111_001_111;
         4'd6:    glyph = 15'b111_100_111_101_111;
         4'd7:    glyph = 15'b111_001_001_001_001;
         4'd8:    glyph = 15'b111_101_111_101_111;
         4'd9:    glyph = 15'b111_101_111_001_111;
         default: glyph = '0;
      endcase
      top = FONT_ROWS*FONT_COLS - 1 - FONT_COLS*int'(row);
      if (top < 0) begin
         top = FONT_COLS - 1;
      end
      return glyph[top -: FONT_COLS];
   endfunction

   // x / 255 for x up to 255*255
   function automatic logic [BRIGHT_W-1:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = 17'(x) + 17'(x[15:8]) + 17'd1;
      return t[15:8];
   endfunction

endpackage

// File: sv/led_matrix_digit_framebuffer_unit.sv
// Top level: sequencer around the shared divider and the frame store.
//
//  channel | signals                                              | direction
//  --------+------------------------------------------------------+----------
//  req     | req_valid, req_stall, req_op, req_number,            | in
//          | req_start_x, req_start_y, req_led_index              |
//  rsp     | rsp_valid, rsp_stall, rsp_led_color                  | out
//  csr     | csr_wr_en, csr_addr, csr_wr_data                     | in
//
// From request transfer to result register: a read passes the divider, the store read,
//   the multiply and the scale; a draw runs the divider once per decimal digit (not
//   for zero), then paints the 5x3 cells of each digit; a clear writes all ROWS*COLS
//   store locations; op 3 or a read past the chain end goes straight to finish.
// Reset: a sweep of ROWS*COLS store writes zeroes the store; req_stall is high meanwhile.
// Stalls: one result register; a finished result waits until it frees up.
module led_matrix_digit_framebuffer_unit #(
   parameter int ROWS       = lmdf_pkg::DEF_ROWS,
   parameter int COLS       = lmdf_pkg::DEF_COLS,
   parameter int MAX_DIGITS = lmdf_pkg::DEF_MAX_DIGITS
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [lmdf_pkg::OP_W-1:0]        req_op,
   input  logic [lmdf_pkg::NUMBER_W-1:0]    req_number,
   input  logic [lmdf_pkg::START_X_W-1:0]   req_start_x,
   input  logic [lmdf_pkg::START_Y_W-1:0]   req_start_y,
   input  logic [lmdf_pkg::LED_INDEX_W-1:0] req_led_index,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [lmdf_pkg::COLOR_W-1:0]     rsp_led_color,
   // register writes
   input  logic                             csr_wr_en,
   input  logic [lmdf_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [lmdf_pkg::COLOR_W-1:0]     csr_wr_data
);
   import lmdf_pkg::*;

   localparam int PIXELS    = ROWS * COLS;
   localparam int ADDR_W    = $clog2(PIXELS);
   localparam int ROW_W     = $clog2(ROWS);
   localparam int CNT_W     = $clog2(MAX_DIGITS + 1);
   localparam int DIG_IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   // widest column a font cell can reach, and widest row
   localparam int X_MAX     = START_X_MAX + (MAX_DIGITS - 1) * DIGIT_PITCH + FONT_COLS - 1;
   localparam int X_W       = $clog2(((X_MAX > COLS) ? X_MAX : COLS) + 1);
   localparam int Y_MAX     = START_Y_MAX + FONT_ROWS - 1;
   localparam int Y_W       = $clog2(((Y_MAX > ROWS) ? Y_MAX : ROWS) + 1);

   typedef enum logic [2:0] {
      S_CLEAR,   // store sweep, after reset or for a clear op
      S_IDLE,
      S_DIGIT,   // waiting on divide by ten
      S_PAINT,   // one font cell per cycle
      S_ROW,     // waiting on divide by COLS
      S_RDWAIT,  // store data back, multiply
      S_SCALE,   // divide products by 255
      S_FINISH   // hand result to output register
   } state_type;

   state_type            state_ff, state_in;
   logic                 clr_reply_ff, clr_reply_in;
   logic [ADDR_W-1:0]    clr_addr_ff, clr_addr_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [CNT_W-1:0]     k_ff, k_in;
   logic [2:0]           r_ff, r_in;
   logic [1:0]           c_ff, c_in;
   logic [3:0]           digs_ff [MAX_DIGITS];
   logic [3:0]           digs_in [MAX_DIGITS];
   logic [START_X_W-1:0] sx_ff, sx_in;
   logic [START_Y_W-1:0] sy_ff, sy_in;
   logic [15:0]          prod_r_ff, prod_r_in;
   logic [15:0]          prod_g_ff, prod_g_in;
   logic [15:0]          prod_b_ff, prod_b_in;
   logic [COLOR_W-1:0]   result_ff, result_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [COLOR_W-1:0]   rsp_color_ff, rsp_color_in;
   logic [BRIGHT_W-1:0]  bright_ff, bright_in;
   logic [COLOR_W-1:0]   color_ff, color_in;

   div_req_type          div_req;
   div_rsp_type          div_rsp;

   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_wr_addr;
   logic [COLOR_W-1:0]   mem_wr_data;
   logic [ADDR_W-1:0]    mem_rd_addr;
   logic [COLOR_W-1:0]   mem_rd_data;

   logic                 req_xfer;
   logic                 out_free;
   logic [CNT_W-1:0]     sel_digit;
   logic [FONT_COLS-1:0] cell_row;
   logic                 cell_lit;
   logic [X_W-1:0]       cell_x;
   logic [Y_W-1:0]       cell_y;
   logic                 cell_on_matrix;
   logic [ROW_W-1:0]     rd_row;
   logic [DIVISOR_W-1:0] rd_col;
   logic [CNT_W-1:0]     cnt_next;
   logic                 last_cell;

   assign req_xfer = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // paint datapath: digits go out most significant first
   assign sel_digit      = cnt_ff - CNT_W'(1) - k_ff;
   assign cell_row       = font_row(digs_ff[sel_digit[DIG_IDX_W-1:0]], r_ff);
   assign cell_lit       = cell_row[2'(FONT_COLS - 1) - c_ff];
   assign cell_x         = X_W'(sx_ff) + X_W'(k_ff) * X_W'(DIGIT_PITCH) + X_W'(c_ff);
   assign cell_y         = Y_W'(sy_ff) + Y_W'(r_ff);
   assign cell_on_matrix = (cell_x < X_W'(COLS)) && (cell_y < Y_W'(ROWS));
   assign last_cell      = (k_ff == cnt_ff - CNT_W'(1)) && (r_ff == 3'(FONT_ROWS - 1)) &&
                           (c_ff == 2'(FONT_COLS - 1));

   // serpentine: odd rows run right to left
   assign rd_row      = div_rsp.quotient[ROW_W-1:0];
   assign rd_col      = rd_row[0] ? (DIVISOR_W'(COLS - 1) - div_rsp.remainder)
                                  : div_rsp.remainder;
   assign mem_rd_addr = ADDR_W'(rd_row) * ADDR_W'(COLS) + ADDR_W'(rd_col);

   assign cnt_next = cnt_ff + CNT_W'(1);

   always_comb begin
      mem_we      = 1'b0;
      mem_wr_addr = clr_addr_ff;
      mem_wr_data = '0;
      if (state_ff == S_CLEAR) begin
         mem_we = 1'b1;
      end else if (state_ff == S_PAINT) begin
         mem_we      = cell_lit && cell_on_matrix;
         mem_wr_addr = ADDR_W'(cell_y) * ADDR_W'(COLS) + ADDR_W'(cell_x);
         mem_wr_data = color_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_reply_in = clr_reply_ff;
      clr_addr_in  = clr_addr_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      r_in         = r_ff;
      c_in         = c_ff;
      digs_in      = digs_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      prod_r_in    = prod_r_ff;
      prod_g_in    = prod_g_ff;
      prod_b_in    = prod_b_ff;
      result_in    = result_ff;
      bright_in    = bright_ff;
      color_in     = color_ff;

      div_req.start    = 1'b0;
      div_req.dividend = req_number;
      div_req.divisor  = DECIMAL_BASE;

      if (csr_wr_en) begin
         case (csr_addr)
            REG_BRIGHTNESS:  bright_in = csr_wr_data[BRIGHT_W-1:0];
            REG_DIGIT_COLOR: color_in  = csr_wr_data;
            default:         ;
         endcase
      end

      case (state_ff)
         S_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == ADDR_W'(PIXELS - 1)) begin
               result_in = '0;
               state_in  = clr_reply_ff ? S_FINISH : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_xfer) begin
               result_in = '0;
               sx_in     = req_start_x;
               sy_in     = req_start_y;
               k_in      = '0;
               r_in      = '0;
               c_in      = '0;
               cnt_in    = '0;
               case (req_op)
                  OP_CLEAR: begin
                     clr_reply_in = 1'b1;
                     clr_addr_in  = '0;
                     state_in     = S_CLEAR;
                  end
                  OP_DRAW: begin
                     if (req_number == '0) begin
                        digs_in[0] = 4'd0;
                        cnt_in     = CNT_W'(1);
                        state_in   = S_PAINT;
                     end else begin
                        div_req.start = 1'b1;
                        state_in      = S_DIGIT;
                     end
                  end
                  OP_READ: begin
                     if (NUMBER_W'(req_led_index) >= NUMBER_W'(PIXELS)) begin
                        state_in = S_FINISH;
                     end else begin
                        div_req.start    = 1'b1;
                        div_req.dividend = NUMBER_W'(req_led_index);
                        div_req.divisor  = DIVISOR_W'(COLS);
                        state_in         = S_ROW;
                     end
                  end
                  default: state_in = S_FINISH;
               endcase
            end
         end
         S_DIGIT: begin
            // least significant digit first; stop at zero quotient or full
            div_req.dividend = div_rsp.quotient;
            if (div_rsp.done) begin
               digs_in[cnt_ff[DIG_IDX_W-1:0]] = div_rsp.remainder[3:0];
               cnt_in = cnt_next;
               if ((div_rsp.quotient == '0) || (cnt_next == CNT_W'(MAX_DIGITS))) begin
                  state_in = S_PAINT;
               end else begin
                  div_req.start = 1'b1;
               end
            end
         end
         S_PAINT: begin
            if (last_cell) begin
               state_in = S_FINISH;
            end else if (c_ff == 2'(FONT_COLS - 1)) begin
               c_in = '0;
               if (r_ff == 3'(FONT_ROWS - 1)) begin
                  r_in = '0;
                  k_in = k_ff + CNT_W'(1);
               end else begin
                  r_in = r_ff + 3'd1;
               end
            end else begin
               c_in = c_ff + 2'd1;
            end
         end
         S_ROW: begin
            // read address goes to the store this cycle
            if (div_rsp.done) begin
               state_in = S_RDWAIT;
            end
         end
         S_RDWAIT: begin
            prod_r_in = 16'(mem_rd_data[23:16]) * 16'(bright_ff);
            prod_g_in = 16'(mem_rd_data[15:8]) * 16'(bright_ff);
            prod_b_in = 16'(mem_rd_data[7:0]) * 16'(bright_ff);
            state_in  = S_SCALE;
         end
         S_SCALE: begin
            result_in = {div255(prod_g_ff), div255(prod_r_ff), div255(prod_b_ff)};
            state_in  = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               clr_reply_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      rsp_valid_in = ((state_ff == S_FINISH) && out_free) || (rsp_valid_ff && rsp_stall);
      rsp_color_in = ((state_ff == S_FINISH) && out_free) ? result_ff : rsp_color_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_reply_ff <= 1'b0;
         clr_addr_ff  <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         bright_ff    <= BRIGHTNESS_RESET;
         color_ff     <= DIGIT_COLOR_RESET;
      end else begin
         state_ff     <= state_in;
         clr_reply_ff <= clr_reply_in;
         clr_addr_ff  <= clr_addr_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         bright_ff    <= bright_in;
         color_ff     <= color_in;
      end
      k_ff         <= k_in;
      r_ff         <= r_in;
      c_ff         <= c_in;
      digs_ff      <= digs_in;
      sx_ff        <= sx_in;
      sy_ff        <= sy_in;
      prod_r_ff    <= prod_r_in;
      prod_g_ff    <= prod_g_in;
      prod_b_ff    <= prod_b_in;
      result_ff    <= result_in;
      rsp_color_ff <= rsp_color_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_led_color = rsp_color_ff;

   lmdf_divider #(
      .COLS (COLS)
   ) u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   lmdf_store #(
      .DEPTH  (PIXELS),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

`ifndef SYNTHESIS
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !mem_we)
      else $error("store written while idle");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_DIGIT || state_ff == S_ROW))
      else $error("divider finished with no waiting step");

   a_digit_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PAINT) |-> (cnt_ff != '0 && cnt_ff <= CNT_W'(MAX_DIGITS)))
      else $error("digit count out of range during paint");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_FINISH))
      else $error("response raised outside finish step");
`endif

endmodule

// File: sv/lmdf_divider.sv
// Constant-divisor divider by reciprocal multiplication, shared by digit extraction and index mapping.
module lmdf_divider #(
   parameter int COLS = lmdf_pkg::DEF_COLS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lmdf_pkg::div_req_type req,
   output lmdf_pkg::div_rsp_type rsp
);
   import lmdf_pkg::*;

   localparam int PROD_W = 2 * NUMBER_W;
   // divide by ten: exact for any 32-bit dividend
   localparam logic [NUMBER_W-1:0] DEC_RECIP = 32'hCCCC_CCCD;
   localparam int                  DEC_SHIFT = 35;
   // divide by COLS: exact for dividends below 128
   localparam int                  COL_SHIFT = 16;
   localparam logic [NUMBER_W-1:0] COL_RECIP = NUMBER_W'(((1 << COL_SHIFT) + COLS - 1) / COLS);

   logic                  pend_ff, pend_in;
   logic                  done_ff, done_in;
   logic                  dec_ff, dec_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [DIVISOR_W-1:0]  dvd_lo_ff, dvd_lo_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [NUMBER_W-1:0]   quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic                  req_dec;
   logic [NUMBER_W-1:0]   quo_calc;
   logic [DIVISOR_W-1:0]  back_lo;

   assign req_dec  = (req.divisor == DECIMAL_BASE);
   assign quo_calc = dec_ff ? NUMBER_W'(prod_ff >> DEC_SHIFT) : NUMBER_W'(prod_ff >> COL_SHIFT);
   // remainder is below the divisor, which fits DIVISOR_W bits, so the low bits of dividend - q*d are enough
   assign back_lo  = DIVISOR_W'(quo_calc[DIVISOR_W-1:0] * dvs_ff);

   always_comb begin
      pend_in   = req.start;
      done_in   = pend_ff;
      dec_in    = dec_ff;
      prod_in   = prod_ff;
      dvd_lo_in = dvd_lo_ff;
      dvs_in    = dvs_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      if (req.start) begin
         dec_in    = req_dec;
         prod_in   = PROD_W'(req.dividend) * PROD_W'(req_dec ? DEC_RECIP : COL_RECIP);
         dvd_lo_in = req.dividend[DIVISOR_W-1:0];
         dvs_in    = req.divisor;
      end
      if (pend_ff) begin
         quo_in = quo_calc;
         rem_in = DIVISOR_W'(dvd_lo_ff - back_lo);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         done_ff <= done_in;
      end
      dec_ff    <= dec_in;
      prod_ff   <= prod_in;
      dvd_lo_ff <= dvd_lo_in;
      dvs_ff    <= dvs_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

// File: sv/lmdf_store.sv
// Frame store: one write port, one registered read port.
module lmdf_store #(
   parameter int DEPTH  = lmdf_pkg::DEF_ROWS * lmdf_pkg::DEF_COLS,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [ADDR_W-1:0]            wr_addr,
   input  logic [lmdf_pkg::COLOR_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]            rd_addr,
   output logic [lmdf_pkg::COLOR_W-1:0] rd_data
);
   import lmdf_pkg::*;

   logic [COLOR_W-1:0] mem_ff [DEPTH];
   logic [COLOR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
